// ===== hdl/utf16le_to_utf8_transcoder_defines.svh =====
// assertion macros shared by the transcoder rtl
`ifndef UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH

`ifndef ASSERT_OFF

`define U16U8_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("implication check failed");

`define U16U8_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`else

`define U16U8_ASSERT_IMPLY(label, cond, prop)

`define U16U8_ASSERT_NEXT(label, cond, prop)

`endif

`endif

// ===== hdl/u16u8_pkg.sv =====
// types, constants and helpers of the utf-16le to utf-8 transcoder
`default_nettype none

package u16u8_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int REPORT_BITS = 32;

  localparam logic [15:0] TAG_MASK = 16'hFC00;
  localparam logic [15:0] TAG_HIGH = 16'hD800;
  localparam logic [15:0] TAG_LOW  = 16'hDC00;
  localparam logic [15:0] LIM_ONE  = 16'h0080;
  localparam logic [15:0] LIM_TWO  = 16'h0800;
  localparam logic [20:0] PLANE_BASE = 21'h10000;

  typedef logic [COUNT_BITS-1:0] count_t;

  // bytes of one character, first byte at index 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_t;

  // everything one input beat hands to the output side
  typedef struct packed {
    logic [3:0][7:0]        bytes;
    logic [1:0]             last_idx;
    logic                   summary;
    logic                   stop;
    logic [REPORT_BITS-1:0] units;
    logic [REPORT_BITS-1:0] nbytes;
  } group_t;

  function automatic count_t sat_add(count_t a, logic [2:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(b);
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [REPORT_BITS-1:0] cap_report(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? '1 : w[REPORT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/u16u8_encode.sv =====
// utf-8 byte encoder for one code unit or one completed surrogate pair
`default_nettype none

module u16u8_encode (
  input  wire logic [15:0]     code_unit,
  input  wire logic [9:0]      pending_high,
  input  wire logic            pair,
  output u16u8_pkg::enc_t      enc
);

  logic [20:0] cp;

  assign cp = u16u8_pkg::PLANE_BASE + 21'({pending_high, code_unit[9:0]});

  always_comb begin
    enc = '0;
    if (pair) begin
      enc.bytes[0] = {5'b11110, cp[20:18]};
      enc.bytes[1] = {2'b10, cp[17:12]};
      enc.bytes[2] = {2'b10, cp[11:6]};
      enc.bytes[3] = {2'b10, cp[5:0]};
      enc.last_idx = 2'd3;
    end else if (code_unit < u16u8_pkg::LIM_ONE) begin
      enc.bytes[0] = code_unit[7:0];
      enc.last_idx = 2'd0;
    end else if (code_unit < u16u8_pkg::LIM_TWO) begin
      enc.bytes[0] = {3'b110, code_unit[10:6]};
      enc.bytes[1] = {2'b10, code_unit[5:0]};
      enc.last_idx = 2'd1;
    end else begin
      enc.bytes[0] = {4'b1110, code_unit[15:12]};
      enc.bytes[1] = {2'b10, code_unit[11:6]};
      enc.bytes[2] = {2'b10, code_unit[5:0]};
      enc.last_idx = 2'd2;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u16u8_serializer.sv =====
// result register that hands out one group of bytes, one beat per cycle while result_ready is high
`default_nettype none

`include "utf16le_to_utf8_transcoder_defines.svh"

module u16u8_serializer (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  load,
  input  wire u16u8_pkg::group_t                     grp,
  output logic                                       free,
  output logic                                       result_valid,
  input  wire logic                                  result_ready,
  output logic [7:0]                                 out_byte,
  output logic                                       last_of_run,
  output logic                                       is_summary,
  output logic                                       stopped_early,
  output logic [u16u8_pkg::REPORT_BITS-1:0]          units_consumed,
  output logic [u16u8_pkg::REPORT_BITS-1:0]          bytes_written
);

  u16u8_pkg::group_t grp_q;
  logic              g_valid;
  logic [1:0]        idx;
  logic              at_last;

  assign at_last = (idx == grp_q.last_idx);
  // free when empty or when the final beat leaves this cycle
  assign free    = !g_valid || (result_ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      idx     <= 2'd0;
    end else if (load) begin
      g_valid <= 1'b1;
      idx     <= 2'd0;
    end else if (g_valid && result_ready) begin
      if (at_last) begin
        g_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_q <= grp;
    end
  end

  assign result_valid   = g_valid;
  assign out_byte       = grp_q.bytes[idx];
  assign last_of_run    = at_last;
  assign is_summary     = grp_q.summary;
  assign stopped_early  = grp_q.stop;
  assign units_consumed = grp_q.units;
  assign bytes_written  = grp_q.nbytes;

  `U16U8_ASSERT_IMPLY(a_idx_in_group, g_valid, idx <= grp_q.last_idx)
  `U16U8_ASSERT_IMPLY(a_summary_single, g_valid && grp_q.summary, grp_q.last_idx == 2'd0)
  `U16U8_ASSERT_NEXT(a_hold_on_stall, g_valid && !result_ready, g_valid && $stable(idx))

endmodule

`default_nettype wire

// ===== hdl/utf16le_to_utf8_transcoder.sv =====
// top level of the utf-16le to utf-8 transcoder
//
//   channel  handshake                    payload
//   item     item_valid / item_ready      command, code_unit
//   result   result_valid / result_ready  out_byte, last_of_run, is_summary,
//                                         stopped_early, units_consumed, bytes_written
//
// one code unit can be taken every cycle while the result register has room for it;
// a unit's bytes leave one per cycle while result_ready is high, which sets the rate
// an item's first result is valid once it has passed the input register and then
// the result register
// a stalled result side stops the input register only when it would load a new group;
// units that give no bytes pass through regardless
// synchronous reset clears the pending surrogate, the halt flag and both counters
`default_nettype none

`include "utf16le_to_utf8_transcoder_defines.svh"

module utf16le_to_utf8_transcoder (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_ready,
  input  wire logic                                  command,
  input  wire logic [15:0]                           code_unit,
  output logic                                       result_valid,
  input  wire logic                                  result_ready,
  output logic [7:0]                                 out_byte,
  output logic                                       last_of_run,
  output logic                                       is_summary,
  output logic                                       stopped_early,
  output logic [u16u8_pkg::REPORT_BITS-1:0]          units_consumed,
  output logic [u16u8_pkg::REPORT_BITS-1:0]          bytes_written
);

  // input register
  logic        s1_valid;
  logic        s1_command;
  logic [15:0] s1_unit;

  // conversion state
  logic [9:0]          pending_high;
  logic                pending_valid;
  logic                halted;
  u16u8_pkg::count_t   unit_count;
  u16u8_pkg::count_t   byte_count;

  logic [15:0]       tag;
  logic              is_high;
  logic              is_low;
  logic              pairing;
  logic              emits;
  logic              s1_go;
  logic              load;
  logic              free;
  logic              state_clear;
  u16u8_pkg::enc_t   enc;
  u16u8_pkg::group_t grp;

  assign tag     = s1_unit & u16u8_pkg::TAG_MASK;
  assign is_high = (tag == u16u8_pkg::TAG_HIGH);
  assign is_low  = (tag == u16u8_pkg::TAG_LOW);
  assign pairing = pending_valid && is_low;

  // does this beat hand a group to the output side
  assign emits = s1_command ||
                 (!halted && (pending_valid ? is_low : (!is_high && !is_low)));

  assign s1_go      = s1_valid && (!emits || free);
  assign load       = s1_go && emits;
  assign item_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_command <= command;
      s1_unit    <= code_unit;
    end
  end

  u16u8_encode u_encode (
    .code_unit    (s1_unit),
    .pending_high (pending_high),
    .pair         (pairing),
    .enc          (enc)
  );

  always_comb begin
    grp = '0;
    if (s1_command) begin
      grp.summary = 1'b1;
      grp.stop    = halted || pending_valid;
      grp.units   = u16u8_pkg::cap_report(unit_count);
      grp.nbytes  = u16u8_pkg::cap_report(byte_count);
    end else begin
      grp.bytes    = enc.bytes;
      grp.last_idx = enc.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high  <= '0;
      pending_valid <= 1'b0;
      halted        <= 1'b0;
      unit_count    <= '0;
      byte_count    <= '0;
    end else if (s1_go) begin
      if (s1_command) begin
        pending_high  <= '0;
        pending_valid <= 1'b0;
        halted        <= 1'b0;
        unit_count    <= '0;
        byte_count    <= '0;
      end else if (!halted) begin
        if (pending_valid) begin
          pending_valid <= 1'b0;
          pending_high  <= '0;
          if (is_low) begin
            unit_count <= u16u8_pkg::sat_add(unit_count, 3'd2);
            byte_count <= u16u8_pkg::sat_add(byte_count, 3'd4);
          end else begin
            // held high surrogate never got its pair
            halted <= 1'b1;
          end
        end else if (is_high) begin
          pending_valid <= 1'b1;
          pending_high  <= s1_unit[9:0];
        end else if (is_low) begin
          halted <= 1'b1;
        end else begin
          unit_count <= u16u8_pkg::sat_add(unit_count, 3'd1);
          byte_count <= u16u8_pkg::sat_add(byte_count, {1'b0, enc.last_idx} + 3'd1);
        end
      end
    end
  end

  u16u8_serializer u_serializer (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .grp            (grp),
    .free           (free),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .is_summary     (is_summary),
    .stopped_early  (stopped_early),
    .units_consumed (units_consumed),
    .bytes_written  (bytes_written)
  );

  assign state_clear = !pending_valid && !halted && (unit_count == '0) && (byte_count == '0);

  `U16U8_ASSERT_IMPLY(a_pending_not_halted, pending_valid, !halted)
  `U16U8_ASSERT_NEXT(a_end_clears, s1_go && s1_command, state_clear)
  `U16U8_ASSERT_NEXT(a_pair_releases, load && !s1_command && pairing, !pending_valid)

endmodule

`default_nettype wire

// ===== bench/utf16le_to_utf8_transcoder_tb.sv =====
// self-checking bench for the utf-16le to utf-8 transcoder: directed units, random strings
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder_tb;

  localparam bit CMD_UNIT = 1'b0;
  localparam bit CMD_END  = 1'b1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 98;
  localparam int DRAIN_CYCLES   = 8;

  // one output beat, fields in port order
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        last;
    logic        summary;
    logic        stop;
    logic [31:0] units;
    logic [31:0] nbytes;
  } beat_t;

  class utf8_scoreboard;
    beat_t       expected_q[$];
    logic [9:0]  held_high;
    bit          held;
    bit          stopped;
    logic [31:0] unit_total;
    logic [31:0] byte_total;
    int          mismatches;
    int          checked;

    function new();
      clear_state();
      mismatches = 0;
      checked = 0;
    endfunction

    function void clear_state();
      held_high = '0;
      held = 1'b0;
      stopped = 1'b0;
      unit_total = '0;
      byte_total = '0;
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, int unsigned b);
      logic [32:0] s;
      s = {1'b0, a} + 33'(b);
      return s[32] ? '1 : s[31:0];
    endfunction

    function void push_byte(logic [7:0] b, bit last);
      beat_t e;
      e = '0;
      e.byte_val = b;
      e.last = last;
      expected_q.push_back(e);
    endfunction

    // advance the utf-16 decoder by one accepted input beat
    function void note_item(bit cmd, logic [15:0] cu);
      beat_t       e;
      logic [20:0] cp;
      logic [15:0] tag;
      tag = cu & u16u8_pkg::TAG_MASK;
      if (cmd == CMD_END) begin
        e = '0;
        e.last = 1'b1;
        e.summary = 1'b1;
        e.stop = stopped || held;
        e.units = unit_total;
        e.nbytes = byte_total;
        expected_q.push_back(e);
        clear_state();
        return;
      end
      if (stopped) return;
      if (held) begin
        // held high surrogate not followed by a low one is the offender
        if (tag != u16u8_pkg::TAG_LOW) begin
          stopped = 1'b1;
          held = 1'b0;
          held_high = '0;
          return;
        end
        cp = u16u8_pkg::PLANE_BASE + 21'({held_high, cu[9:0]});
        held = 1'b0;
        held_high = '0;
        push_byte({5'b11110, cp[20:18]}, 1'b0);
        push_byte({2'b10, cp[17:12]}, 1'b0);
        push_byte({2'b10, cp[11:6]}, 1'b0);
        push_byte({2'b10, cp[5:0]}, 1'b1);
        unit_total = add_sat(unit_total, 2);
        byte_total = add_sat(byte_total, 4);
      end else if (tag == u16u8_pkg::TAG_HIGH) begin
        held_high = cu[9:0];
        held = 1'b1;
      end else if (tag == u16u8_pkg::TAG_LOW) begin
        stopped = 1'b1;
      end else if (cu < u16u8_pkg::LIM_ONE) begin
        push_byte(cu[7:0], 1'b1);
        unit_total = add_sat(unit_total, 1);
        byte_total = add_sat(byte_total, 1);
      end else if (cu < u16u8_pkg::LIM_TWO) begin
        push_byte({3'b110, cu[10:6]}, 1'b0);
        push_byte({2'b10, cu[5:0]}, 1'b1);
        unit_total = add_sat(unit_total, 1);
        byte_total = add_sat(byte_total, 2);
      end else begin
        push_byte({4'b1110, cu[15:12]}, 1'b0);
        push_byte({2'b10, cu[11:6]}, 1'b0);
        push_byte({2'b10, cu[5:0]}, 1'b1);
        unit_total = add_sat(unit_total, 1);
        byte_total = add_sat(byte_total, 3);
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] extra beat: byte %02h last %0b summ %0b stop %0b units %0d bytes %0d",
                   $realtime, got.byte_val, got.last, got.summary, got.stop,
                   got.units, got.nbytes);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] beat mismatch", $realtime);
          $display("  expected: byte %02h last %0b summ %0b stop %0b units %0d bytes %0d",
                   e.byte_val, e.last, e.summary, e.stop, e.units, e.nbytes);
          $display("  actual:   byte %02h last %0b summ %0b stop %0b units %0d bytes %0d",
                   got.byte_val, got.last, got.summary, got.stop, got.units, got.nbytes);
        end
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        command = 1'b0;
  logic [15:0] code_unit = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        is_summary;
  logic        stopped_early;
  logic [u16u8_pkg::REPORT_BITS-1:0] units_consumed;
  logic [u16u8_pkg::REPORT_BITS-1:0] bytes_written;

  utf8_scoreboard sb;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;
  int strings_sent = 0;
  int stall_cycles = 0;

  utf16le_to_utf8_transcoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .command        (command),
    .code_unit      (code_unit),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .is_summary     (is_summary),
    .stopped_early  (stopped_early),
    .units_consumed (units_consumed),
    .bytes_written  (bytes_written)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // beat monitor and stall counter
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_item(command, code_unit);
      if (result_valid && result_ready)
        sb.check_beat({out_byte, last_of_run, is_summary, stopped_early,
                       units_consumed, bytes_written});
      if ((item_valid && item_ready) || (result_valid && result_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("no beat for %0d cycles, %0d results still expected",
             WATCHDOG_LIMIT, sb.outstanding());
    $display("Verification failed");
    $finish;
  end

  // called at a falling edge, returns at a falling edge with the beat taken
  task automatic send_item(input bit cmd, input logic [15:0] cu);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    code_unit <= cu;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic send_char();
    int          kind;
    logic [15:0] hi;
    kind = $urandom_range(99);
    hi = 16'($urandom_range(16'hDBFF, 16'hD800));
    if (kind < 30) begin
      send_item(CMD_UNIT, 16'($urandom_range(16'h007F)));
    end else if (kind < 50) begin
      send_item(CMD_UNIT, 16'($urandom_range(16'h07FF, 16'h0080)));
    end else if (kind < 62) begin
      send_item(CMD_UNIT, 16'($urandom_range(16'hD7FF, 16'h0800)));
    end else if (kind < 75) begin
      send_item(CMD_UNIT, 16'($urandom_range(16'hFFFF, 16'hE000)));
    end else begin
      send_item(CMD_UNIT, hi);
      send_item(CMD_UNIT, 16'($urandom_range(16'hDFFF, 16'hDC00)));
    end
  endtask

  // one string of random content closed by an end command
  task automatic send_string();
    int n;
    int fault;
    n = $urandom_range(10, 1);
    fault = $urandom_range(99);
    for (int i = 0; i < n; i++) begin
      if (fault >= 80 && i == n / 2) begin
        case ($urandom_range(3))
          0: send_item(CMD_UNIT, 16'($urandom_range(16'hDFFF, 16'hDC00)));
          1: begin
            send_item(CMD_UNIT, 16'($urandom_range(16'hDBFF, 16'hD800)));
            send_item(CMD_UNIT, 16'($urandom_range(16'hD7FF)));
          end
          2: begin
            send_item(CMD_UNIT, 16'($urandom_range(16'hDBFF, 16'hD800)));
            send_item(CMD_UNIT, 16'($urandom_range(16'hDBFF, 16'hD800)));
          end
          default: send_item(CMD_UNIT, 16'($urandom_range(16'hFFFF)));
        endcase
      end else if (fault >= 70 && $urandom_range(3) == 0) begin
        // noise: any unit at all
        send_item(CMD_UNIT, 16'($urandom_range(16'hFFFF)));
      end else begin
        send_char();
      end
    end
    // dangling high surrogate at the end now and then
    if ($urandom_range(9) == 0) send_item(CMD_UNIT, 16'($urandom_range(16'hDBFF, 16'hD800)));
    send_item(CMD_END, 16'($urandom_range(16'hFFFF)));
    strings_sent++;
  endtask

  logic [16:0] directed_items[] = '{
    {CMD_UNIT, 16'h0000}, {CMD_UNIT, 16'h007F}, {CMD_UNIT, 16'h0080},
    {CMD_UNIT, 16'h07FF}, {CMD_UNIT, 16'h0800}, {CMD_UNIT, 16'hD7FF},
    {CMD_UNIT, 16'hE000}, {CMD_UNIT, 16'hFFFF}, {CMD_UNIT, 16'hD800},
    {CMD_UNIT, 16'hDC00}, {CMD_UNIT, 16'hDBFF}, {CMD_UNIT, 16'hDFFF},
    {CMD_END,  16'hFFFF},
    // lone low surrogate halts, later units are dropped
    {CMD_UNIT, 16'hDC00}, {CMD_UNIT, 16'h0041}, {CMD_END, 16'h0000},
    // high surrogate followed by a plain unit
    {CMD_UNIT, 16'hD800}, {CMD_UNIT, 16'h0041}, {CMD_END, 16'h0000},
    // end with a high surrogate still held
    {CMD_UNIT, 16'hDBFF}, {CMD_END, 16'h5555},
    // two highs in a row
    {CMD_UNIT, 16'hDA00}, {CMD_UNIT, 16'hD900}, {CMD_END, 16'hAAAA}
  };

  initial begin : stimulus
    int src_pct[4];
    int sink_pct[4];
    int target;
    src_pct = '{0, 59, 0, 29};
    sink_pct = '{0, 0, 59, 29};
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_items[i]) send_item(directed_items[i][16], directed_items[i][15:0]);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pct[p];
      sink_stall_pct = sink_pct[p];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_string();
      // sender holds off until the output side has caught up
      drain_results();
    end

    item_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d input beats in %0d random strings plus directed units,",
             items_sent, strings_sent);
    $display("%0d result beats compared under four sender/receiver idle mixes",
             sb.checked);
    if (sb.outstanding() != 0)
      $display("%0d expected results never arrived", sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/u16u8_pkg.sv
hdl/u16u8_encode.sv
hdl/u16u8_serializer.sv
hdl/utf16le_to_utf8_transcoder.sv
bench/utf16le_to_utf8_transcoder_tb.sv
